### hdl/nsf_pkg.sv
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types, character codes and the sentence name table of the NMEA
// sentence framer.
// ----------------------------------------------------------------------------
`default_nettype none

package nsf_pkg;

    // Parser mode
    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_BODY,
        MODE_HEX1,
        MODE_HEX2
    } mode_t;

    // Event codes on the result stream
    localparam logic [1:0] EV_DATA = 2'd0;
    localparam logic [1:0] EV_SEP  = 2'd1;
    localparam logic [1:0] EV_END  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_P      = 8'h50;

    // Name buffer
    localparam int NAME_DEPTH   = 7;
    localparam int NAME_MAX_LEN = 6;
    localparam int NUM_NAMES    = 16;
    typedef logic [NAME_DEPTH-1:0][7:0] name_buf_t;

    localparam logic [4:0] KIND_UNKNOWN = 5'd16;

    // Table entry: text is left aligned, first character in the top byte
    typedef struct packed {
        logic        vendor;
        logic [2:0]  len;
        logic [47:0] text;
    } name_entry_t;

    localparam name_entry_t NAME_TABLE [NUM_NAMES] = '{
        '{1'b0, 3'd3, "RMC   "}, '{1'b0, 3'd3, "GGA   "},
        '{1'b0, 3'd3, "GSA   "}, '{1'b0, 3'd3, "GSV   "},
        '{1'b0, 3'd3, "GLL   "}, '{1'b0, 3'd3, "RTE   "},
        '{1'b0, 3'd3, "RMB   "}, '{1'b0, 3'd3, "BOD   "},
        '{1'b1, 3'd4, "GRME  "}, '{1'b1, 3'd4, "GRMM  "},
        '{1'b1, 3'd4, "GRMZ  "},
        '{1'b1, 3'd6, "XRMADD"}, '{1'b1, 3'd6, "XRMMOV"},
        '{1'b1, 3'd6, "XRMDEL"}, '{1'b1, 3'd6, "XRMSUB"},
        '{1'b1, 3'd6, "XRMCFG"}
    };

endpackage

`default_nettype wire

### hdl/nsf_name_classifier.sv
// ----------------------------------------------------------------------------
// nsf_name_classifier
// Matches the buffered sentence name against the fixed name table. Vendor
// names skip the leading 'P', others skip two talker characters.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_name_classifier
    import nsf_pkg::*;
(
    input  wire name_buf_t   name_chars,
    input  wire logic [3:0]  name_length,
    output logic      [4:0]  kind
);

    logic       vendor;
    logic [2:0] skip;
    logic       same;

    // Parallel compare against every entry, lowest matching index wins
    always_comb
    begin
        vendor = (name_chars[0] == CH_P);
        skip   = vendor ? 3'd1 : 3'd2;
        kind   = KIND_UNKNOWN;
        same   = 1'b0;
        for (int i = NUM_NAMES - 1; i >= 0; i--)
        begin
            same = (NAME_TABLE[i].vendor == vendor) &&
                   (name_length == ({1'b0, NAME_TABLE[i].len} + {1'b0, skip}));
            for (int k = 0; k < NAME_MAX_LEN; k++)
            begin
                if (same && (k < int'(NAME_TABLE[i].len)))
                begin
                    same = (name_chars[3'(skip + 3'(k))] ==
                            NAME_TABLE[i].text[47 - 8 * k -: 8]);
                end
            end
            if (same && (name_length != 4'd0) && (name_length <= 4'(NAME_DEPTH)))
            begin
                kind = 5'(i);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/nmea_sentence_framer_unit.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_unit
// Frames NMEA 0183 sentences from a byte stream: emits body bytes with their
// field number, separators, and an end event with kind, count and checksum.
// ----------------------------------------------------------------------------
// A result is in the output register in the cycle after its byte transfer.
// Throughput: one byte per cycle unless a full output register waits for m_tready,
// also for bytes that make no result ('$', '*', first digit, hunting).
// Reset: asynchronous, active low; parser returns to hunting for '$' and the
// output register empties. The name buffer needs no reset.
`default_nettype none

module nmea_sentence_framer_unit
    import nsf_pkg::*;
#(
    parameter int MAX_FIELDS = 80
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] char_out, [14:8] field_index, [19:15] sentence_kind,
    // [26:20] field_count, [34:27] computed_sum, [35] sum_present,
    // [36] sum_ok, [37] fields_overflowed, [39:38] zero
    output logic [39:0]      m_tdata,
    output logic [1:0]       m_tuser    // [1:0] event_kind
);

    localparam logic [6:0] LAST_FIELD = 7'(MAX_FIELDS - 1);

    typedef struct packed {
        logic        overflowed;
        logic        ok;
        logic        present;
        logic [7:0]  sum;
        logic [6:0]  count;
        logic [4:0]  kind;
        logic [6:0]  index;
        logic [7:0]  char_out;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

    mode_t      mode_reg, mode_next;
    logic [7:0] xor_reg, xor_next;
    logic [3:0] upper_reg, upper_next;
    logic [6:0] field_reg, field_next;
    logic [3:0] name_len_reg, name_len_next;
    logic [4:0] kind_reg, kind_next;
    logic       ovf_reg, ovf_next;
    name_buf_t  name_chars_reg;
    logic       name_wr;

    logic       out_valid_reg;
    result_t    out_data_reg;
    logic [1:0] out_event_reg;

    logic       res_fire;
    result_t    res_data;
    logic [1:0] res_event;

    logic       s_fire;
    logic       is_control;
    logic [4:0] class_kind;
    logic [7:0] rx_sum;

    assign s_tready   = !out_valid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;
    assign is_control = (s_tdata < CH_SPACE);
    assign rx_sum     = {upper_reg, hex_value(s_tdata)};

    // Name table match on the current name buffer
    nsf_name_classifier u_classifier (
        .name_chars  (name_chars_reg),
        .name_length (name_len_reg),
        .kind        (class_kind)
    );

    // Parser next state and result
    always_comb
    begin
        mode_next     = mode_reg;
        xor_next      = xor_reg;
        upper_next    = upper_reg;
        field_next    = field_reg;
        name_len_next = name_len_reg;
        kind_next     = kind_reg;
        ovf_next      = ovf_reg;
        name_wr       = 1'b0;
        res_fire      = 1'b0;
        res_event     = EV_DATA;
        res_data      = '0;

        // end event fields; present/ok filled in per case
        if (s_fire && (mode_reg != MODE_HUNT) &&
            (is_control || (mode_reg == MODE_HEX2)))
        begin
            res_fire       = 1'b1;
            res_event      = EV_END;
            res_data.index = field_reg;
            res_data.kind  = (field_reg == 7'd0) ? class_kind : kind_reg;
            res_data.count = field_reg + 7'd1;
            res_data.sum   = xor_reg;
            res_data.overflowed = ovf_reg;
            kind_next      = res_data.kind;
            mode_next      = MODE_HUNT;
            if (!is_control)
            begin
                res_data.present = 1'b1;
                res_data.ok      = (rx_sum == xor_reg);
            end
        end
        else if (s_fire)
        begin
            case (mode_reg)
                MODE_HUNT:
                begin
                    if (s_tdata == CH_DOLLAR)
                    begin
                        mode_next     = MODE_BODY;
                        xor_next      = 8'd0;
                        upper_next    = 4'd0;
                        field_next    = 7'd0;
                        name_len_next = 4'd0;
                        kind_next     = KIND_UNKNOWN;
                        ovf_next      = 1'b0;
                    end
                end
                MODE_BODY:
                begin
                    if (s_tdata == CH_STAR)
                    begin
                        mode_next = MODE_HEX1;
                    end
                    else
                    begin
                        xor_next          = xor_reg ^ s_tdata;
                        res_fire          = 1'b1;
                        res_data.char_out = s_tdata;
                        if (s_tdata == CH_COMMA)
                        begin
                            if (field_reg == 7'd0) kind_next = class_kind;
                            if (field_reg >= LAST_FIELD)
                            begin
                                field_next = LAST_FIELD;
                                ovf_next   = 1'b1;
                            end
                            else
                            begin
                                field_next = field_reg + 7'd1;
                            end
                            res_event      = EV_SEP;
                            res_data.index = field_next;
                        end
                        else
                        begin
                            if (field_reg == 7'd0)
                            begin
                                name_wr = (name_len_reg < 4'(NAME_DEPTH));
                                if (name_len_reg <= 4'(NAME_DEPTH))
                                    name_len_next = name_len_reg + 4'd1;
                            end
                            res_event      = EV_DATA;
                            res_data.index = field_reg;
                        end
                    end
                end
                MODE_HEX1:
                begin
                    upper_next = hex_value(s_tdata);
                    mode_next  = MODE_HEX2;
                end
                default:
                begin
                    mode_next = MODE_HUNT;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_HUNT;
            xor_reg      <= 8'd0;
            upper_reg    <= 4'd0;
            field_reg    <= 7'd0;
            name_len_reg <= 4'd0;
            kind_reg     <= KIND_UNKNOWN;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            xor_reg      <= xor_next;
            upper_reg    <= upper_next;
            field_reg    <= field_next;
            name_len_reg <= name_len_next;
            kind_reg     <= kind_next;
            ovf_reg      <= ovf_next;
        end
    end

    // Name buffer
    always_ff @(posedge clk)
    begin
        if (name_wr)
            name_chars_reg[name_len_reg[2:0]] <= s_tdata;
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= res_fire;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s_tready && res_fire)
        begin
            out_data_reg  <= res_data;
            out_event_reg <= res_event;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tuser  = out_event_reg;

    // Checks
    a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg <= LAST_FIELD)
        else $error("field number beyond last field");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (field_reg == LAST_FIELD))
        else $error("overflow flag without saturated field number");

    a_name_len: assert property (@(posedge clk) disable iff (!rst_n)
        name_len_reg <= 4'(NAME_DEPTH + 1))
        else $error("name length out of range");

    a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_END)) |->
        ((m_tdata[26:20] == m_tdata[14:8] + 7'd1) && (m_tdata[7:0] == 8'd0)))
        else $error("end event count does not follow field index");

    a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != EV_END)) |->
        ((m_tdata[37:15] == 23'd0) && (m_tuser == EV_DATA || m_tuser == EV_SEP)))
        else $error("body event carries end fields");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nmea_sentence_framer_unit. A short table of
// directed bytes is followed by randomly generated sentences: known, vendor,
// near-miss and garbage names, good and corrupted checksums, control-byte
// endings and field overflow. Both stream sides idle in random bursts, and
// every result transfer is checked against an in-bench sentence predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import nsf_pkg::*;

    localparam int FIELD_LIMIT  = 80;
    localparam int TARGET_BYTES = 1750;
    localparam int QUIET_AFTER  = 1600;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_CYCLES  = 4;

    // One result event, fields as the block reports them
    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] ch;
        logic [6:0] fidx;
        logic [4:0] skind;
        logic [6:0] fcount;
        logic [7:0] sum;
        logic       present;
        logic       ok;
        logic       ovf;
    } evt_t;

    typedef struct {
        logic [7:0] b;
        bit         lit;
        evt_t       r;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    nmea_sentence_framer_unit #(.MAX_FIELDS(FIELD_LIMIT)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state
    mode_t      pm;
    logic [7:0] p_xor;
    logic [3:0] p_hi;
    logic [6:0] p_field;
    logic [7:0] p_name [0:6];
    logic [3:0] p_nlen;
    logic [4:0] p_kind;
    logic       p_ovf;

    evt_t       pending_events [$];
    dir_row_t   dir_tab [$];

    bit tx_gaps;
    bit rx_gaps;
    bit long_req;
    int hold_left;
    int mismatches;
    int cycles;
    int n_sent, n_useful, n_sentences;
    int n_checked, n_ends, n_good, n_ovf;

    // Sentence names, talker names first, then vendor names after 'P'
    function automatic string table_name(input int i);
        case (i)
            0:  return "RMC";
            1:  return "GGA";
            2:  return "GSA";
            3:  return "GSV";
            4:  return "GLL";
            5:  return "RTE";
            6:  return "RMB";
            7:  return "BOD";
            8:  return "GRME";
            9:  return "GRMM";
            10: return "GRMZ";
            11: return "XRMADD";
            12: return "XRMMOV";
            13: return "XRMDEL";
            14: return "XRMSUB";
            15: return "XRMCFG";
            default: return "";
        endcase
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
        if (n < 10) return "0" + n;
        return 8'((lower ? "a" : "A") + n - 8'd10);
    endfunction

    // Match the collected name against the table
    function automatic logic [4:0] name_kind();
        bit    vend;
        bit    same;
        int    skip;
        string s;
        if (p_nlen == 0 || p_nlen > 7) return KIND_UNKNOWN;
        vend = (p_name[0] == CH_P);
        skip = vend ? 1 : 2;
        for (int i = 0; i < 16; i++) begin
            s = table_name(i);
            if ((i >= 8) != vend) continue;
            if (p_nlen != skip + s.len()) continue;
            same = 1'b1;
            for (int k = 0; k < s.len(); k++)
                if (p_name[skip + k] != s[k]) same = 1'b0;
            if (same) return i[4:0];
        end
        return KIND_UNKNOWN;
    endfunction

    function automatic evt_t body_evt(input logic [1:0] ev, input logic [7:0] ch,
                                      input logic [6:0] fidx);
        evt_t e;
        e = '0;
        e.ev = ev;
        e.ch = ch;
        e.fidx = fidx;
        return e;
    endfunction

    task automatic close_sentence(input bit pres, input bit ok, output evt_t r);
        if (p_field == 0) p_kind = name_kind();
        r = '0;
        r.ev = EV_END;
        r.fidx = p_field;
        r.skind = p_kind;
        r.fcount = p_field + 7'd1;
        r.sum = p_xor;
        r.present = pres;
        r.ok = ok;
        r.ovf = p_ovf;
        pm = MODE_HUNT;
    endtask

    // Advance the sentence predictor by one accepted byte
    task automatic frame_step(input logic [7:0] b, output bit has, output bit ign,
                              output evt_t r);
        bit ctl;
        logic [7:0] rx;
        has = 1'b0;
        ign = 1'b0;
        r = '0;
        ctl = (b < 8'h20);
        case (pm)
            MODE_HUNT:
            begin
                ign = (b != CH_DOLLAR);
                if (!ign)
                begin
                    pm = MODE_BODY;
                    p_xor = '0;
                    p_hi = '0;
                    p_field = '0;
                    p_nlen = '0;
                    p_kind = KIND_UNKNOWN;
                    p_ovf = 1'b0;
                end
            end
            MODE_BODY:
            begin
                if (ctl)
                begin
                    close_sentence(1'b0, 1'b0, r);
                    has = 1'b1;
                end
                else if (b == CH_STAR)
                    pm = MODE_HEX1;
                else
                begin
                    p_xor ^= b;
                    if (b == CH_COMMA)
                    begin
                        if (p_field == 0) p_kind = name_kind();
                        if (p_field >= FIELD_LIMIT - 1)
                        begin
                            p_field = 7'(FIELD_LIMIT - 1);
                            p_ovf = 1'b1;
                        end
                        else
                            p_field++;
                        r = body_evt(EV_SEP, b, p_field);
                    end
                    else
                    begin
                        if (p_field == 0)
                        begin
                            if (p_nlen < 7) p_name[p_nlen[2:0]] = b;
                            if (p_nlen <= 7) p_nlen++;
                        end
                        r = body_evt(EV_DATA, b, p_field);
                    end
                    has = 1'b1;
                end
            end
            MODE_HEX1:
            begin
                if (ctl)
                begin
                    close_sentence(1'b0, 1'b0, r);
                    has = 1'b1;
                end
                else
                begin
                    p_hi = nibble_of(b);
                    pm = MODE_HEX2;
                end
            end
            default:
            begin
                rx = {p_hi, nibble_of(b)};
                if (ctl)
                    close_sentence(1'b0, 1'b0, r);
                else
                    close_sentence(1'b1, rx == p_xor, r);
                has = 1'b1;
            end
        endcase
    endtask

    // One byte transfer on the input side, with an optional idle burst first
    task automatic send_byte(input logic [7:0] b, output bit has, output bit ign,
                             output evt_t r);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
        n_sent++;
        frame_step(b, has, ign, r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        bit has;
        bit ign;
        evt_t r;
        send_byte(b, has, ign, r);
        if (has) pending_events.push_back(r);
        if (!ign) n_useful++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
    endtask

    task automatic row(input logic [7:0] b);
        dir_row_t d;
        d.b = b;
        d.lit = 1'b0;
        d.r = '0;
        dir_tab.push_back(d);
    endtask

    task automatic row_lit(input logic [7:0] b, input evt_t r);
        dir_row_t d;
        d.b = b;
        d.lit = 1'b1;
        d.r = r;
        dir_tab.push_back(d);
    endtask

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            c = CH_DOLLAR;
        else if (sel < 3)
            c = 8'($urandom_range(8'h80, 8'hFF));
        else
            c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_COMMA || c == CH_STAR) c = "A";
        return c;
    endfunction

    // One random sentence with optional leading noise
    task automatic gen_sentence(input bit big);
        int style, nf, flen, idx, ending, n;
        string nm;
        logic [7:0] c;
        logic [7:0] sum;
        bit lower;
        style = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                c = 8'($urandom);
                if (c == CH_DOLLAR) c = 8'h00;
                put_byte(c);
            end
        end
        put_byte(CH_DOLLAR);

        // sentence name
        if (style < 70)
        begin
            idx = $urandom_range(0, 15);
            nm = table_name(idx);
            if (idx >= 8)
                put_byte(CH_P);
            else
            begin
                put_byte(8'($urandom_range("A", "Z")));
                put_byte(8'($urandom_range("A", "Z")));
            end
            for (int k = 0; k < nm.len(); k++) put_byte(nm[k]);
        end
        else if (style < 85)
        begin
            n = $urandom_range(0, 9);
            for (int k = 0; k < n; k++)
            begin
                if (k == 0 && $urandom_range(0, 2) == 0)
                    put_byte(CH_P);
                else
                    put_byte(8'($urandom_range("A", "Z")));
            end
        end
        else if (style < 93)
        begin
            // near miss: one letter of a known name changed
            idx = $urandom_range(0, 15);
            nm = table_name(idx);
            n = $urandom_range(0, nm.len() - 1);
            if (idx >= 8) put_byte(CH_P);
            else
            begin
                put_byte("G");
                put_byte("P");
            end
            for (int k = 0; k < nm.len(); k++)
                put_byte(k == n ? 8'(nm[k] ^ 8'h01) : 8'(nm[k]));
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n) put_byte(body_char());
        end

        // fields
        nf = big ? $urandom_range(77, 90) : $urandom_range(0, 8);
        repeat (nf)
        begin
            put_byte(CH_COMMA);
            flen = big ? $urandom_range(0, 1) : $urandom_range(0, 6);
            repeat (flen) put_byte(body_char());
        end

        // ending
        ending = $urandom_range(0, 9);
        lower = ($urandom_range(0, 1) != 0);
        if (ending <= 5)
        begin
            put_byte(CH_STAR);
            sum = p_xor;
            if ($urandom_range(0, 3) == 0) sum ^= 8'($urandom_range(1, 255));
            put_byte(hex_digit(sum[7:4], lower));
            put_byte(hex_digit(sum[3:0], lower));
        end
        else if (ending == 6)
            put_byte(8'($urandom_range(8'h00, 8'h1F)));
        else if (ending == 7)
        begin
            put_byte(CH_STAR);
            put_byte(8'($urandom_range(8'h00, 8'h1F)));
        end
        else if (ending == 8)
        begin
            put_byte(CH_STAR);
            put_byte(hex_digit(p_xor[7:4], lower));
            put_byte(8'($urandom_range(8'h00, 8'h1F)));
        end
        else
        begin
            put_byte(CH_STAR);
            put_byte(8'($urandom_range(8'h20, 8'hFF)));
            put_byte(8'($urandom_range(8'h20, 8'hFF)));
        end

        // trailing line end, ignored while hunting
        if ($urandom_range(0, 1) == 0)
        begin
            put_byte(8'h0D);
            put_byte(8'h0A);
        end
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 30)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
        end
    endtask

    // Receiver: random stall bursts and a long hold-off on each request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (long_req)
        begin
            long_req = 1'b0;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (rx_gaps && $urandom_range(0, 7) == 0)
        begin
            hold_left <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result checker
    always @(posedge clk)
    begin : result_check
        evt_t got;
        evt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ev      = m_tuser;
            got.ch      = m_tdata[7:0];
            got.fidx    = m_tdata[14:8];
            got.skind   = m_tdata[19:15];
            got.fcount  = m_tdata[26:20];
            got.sum     = m_tdata[34:27];
            got.present = m_tdata[35];
            got.ok      = m_tdata[36];
            got.ovf     = m_tdata[37];
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 30)
                    $display("%0t ns: result with nothing expected, expected none, actual %h",
                             $time, got);
            end
            else
            begin
                want = pending_events.pop_front();
                n_checked++;
                if (want.ev == EV_END)
                begin
                    n_ends++;
                    if (want.ok) n_good++;
                    if (want.ovf) n_ovf++;
                end
                check_field("event_kind", want.ev, got.ev);
                check_field("char_out", want.ch, got.ch);
                check_field("field_index", want.fidx, got.fidx);
                check_field("sentence_kind", want.skind, got.skind);
                check_field("field_count", want.fcount, got.fcount);
                check_field("computed_sum", want.sum, got.sum);
                check_field("sum_present", want.present, got.present);
                check_field("sum_ok", want.ok, got.ok);
                check_field("fields_overflowed", want.ovf, got.ovf);
                check_field("tdata padding", 0, m_tdata[39:38]);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_events.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        bit has;
        bit ign;
        evt_t r;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        long_req = 1'b0;
        hold_left = 0;
        cycles = 0;
        mismatches = 0;
        n_sent = 0;
        n_useful = 0;
        n_sentences = 0;
        n_checked = 0;
        n_ends = 0;
        n_good = 0;
        n_ovf = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // predictor reset
        pm = MODE_HUNT;
        p_xor = '0;
        p_hi = '0;
        p_field = '0;
        p_nlen = '0;
        p_kind = KIND_UNKNOWN;
        p_ovf = 1'b0;
        foreach (p_name[i]) p_name[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bytes: hunting noise, a talker sentence with odd body bytes,
        // non-hex checksum digits, an empty sentence cut in the checksum,
        // and a vendor start ended by a control byte in the body
        row(8'hFF);
        row(8'h00);
        row(CH_DOLLAR);
        row_lit("G", body_evt(EV_DATA, "G", 7'd0));
        row_lit("P", body_evt(EV_DATA, "P", 7'd0));
        row_lit("R", body_evt(EV_DATA, "R", 7'd0));
        row_lit("M", body_evt(EV_DATA, "M", 7'd0));
        row_lit("C", body_evt(EV_DATA, "C", 7'd0));
        row_lit(CH_COMMA, body_evt(EV_SEP, CH_COMMA, 7'd1));
        row_lit(CH_DOLLAR, body_evt(EV_DATA, CH_DOLLAR, 7'd1));
        row_lit(8'hFF, body_evt(EV_DATA, 8'hFF, 7'd1));
        row_lit(CH_SPACE, body_evt(EV_DATA, CH_SPACE, 7'd1));
        row_lit(8'h80, body_evt(EV_DATA, 8'h80, 7'd1));
        row(CH_STAR);
        row("Z");
        row("x");
        row(CH_DOLLAR);
        row(CH_STAR);
        row_lit(8'h0D, '{EV_END, 8'h00, 7'd0, KIND_UNKNOWN, 7'd1, 8'h00,
                         1'b0, 1'b0, 1'b0});
        row(CH_DOLLAR);
        row_lit("P", body_evt(EV_DATA, "P", 7'd0));
        row_lit(8'h7F, body_evt(EV_DATA, 8'h7F, 7'd0));
        row(8'h1F);

        foreach (dir_tab[i])
        begin
            send_byte(dir_tab[i].b, has, ign, r);
            if (dir_tab[i].lit)
                pending_events.push_back(dir_tab[i].r);
            else if (has)
                pending_events.push_back(r);
        end
        wait_results();

        // random sentences
        while (n_useful < TARGET_BYTES)
        begin
            n_sentences++;
            if (n_useful > QUIET_AFTER)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            else
            begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            if (n_sentences == 15 || n_sentences == 30) long_req = 1'b1;
            if (n_sentences == 45) wait_results();
            gen_sentence(n_sentences % 30 == 10);
        end

        wait_results();
        repeat (PIPE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d random sentences plus the directed table.",
                 n_sent, n_sentences);
        $display("Checked %0d results: %0d sentence ends, %0d good checksums, %0d overflowed.",
                 n_checked, n_ends, n_good, n_ovf);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
